// ===== rtl/core/lgmc_pkg.sv =====
// lgmc_pkg: shared types, codes and helpers of the landing guidance mode controller
// used by lgmc_alu and landing_guidance_mode_controller_unit; no dependencies
`default_nettype none
package lgmc_pkg;

    // flight modes, same encoding as the mode command
    typedef enum logic [2:0] {
        MODE_TAKEOFF = 3'd0,
        MODE_STAB    = 3'd1,
        MODE_TRACK   = 3'd2,
        MODE_LAND    = 3'd3,
        MODE_IDLE    = 3'd4
    } mode_t;

    // event kinds carried on s_tuser
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_DET   = 2'd1,
        OP_ALT   = 2'd2,
        OP_MODE  = 2'd3
    } opcode_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_MAX_SPEED   = 3'd0,
        CFG_CLIMB_SPEED = 3'd1,
        CFG_TAKEOFF_ALT = 3'd2,
        CFG_LANDING_ALT = 3'd3,
        CFG_CAPTURE_RAD = 3'd4,
        CFG_HOVER_OFS   = 3'd5,
        CFG_TAG_TIMEOUT = 3'd6
    } cfg_index_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQM,
        ST_SQRT,
        ST_CHK,
        ST_PMUL,
        ST_DIV,
        ST_OUT
    } state_t;

    localparam int ALU_W = 67;

    // request to the shared adder / subtractor
    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             borrow;
    } alu_rsp_t;

    // negate with the most negative value saturating to the most positive
    function automatic logic [31:0] neg_sat(input logic [31:0] v);
        logic [31:0] r;
        if (v == 32'h8000_0000) begin
            r = 32'h7FFF_FFFF;
        end else begin
            r = 32'd0 - v;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/lgmc_alu.sv =====
// lgmc_alu: wide add / subtract with borrow, shared by multiply, root and divide steps
// depends on lgmc_pkg
`default_nettype none
module lgmc_alu (
    input  wire lgmc_pkg::alu_req_t req,
    output lgmc_pkg::alu_rsp_t      rsp
);

    logic [lgmc_pkg::ALU_W:0] full;

    // subtract as add of inverted operand plus one
    always_comb begin
        full = {1'b0, req.a}
             + {1'b0, (req.sub ? ~req.b : req.b)}
             + {{lgmc_pkg::ALU_W{1'b0}}, req.sub};
        rsp.res    = full[lgmc_pkg::ALU_W-1:0];
        rsp.borrow = req.sub & ~full[lgmc_pkg::ALU_W];
    end

endmodule
`default_nettype wire

// ===== rtl/core/landing_guidance_mode_controller_unit.sv =====
// landing_guidance_mode_controller_unit: top level, event decode, mode logic and sequencer
// depends on lgmc_pkg and lgmc_alu
//
//  channel | direction | handshake            | contents
//  s_      | in        | s_tvalid / s_tready  | tuser opcode, tdata pos_a pos_b pos_c new_mode
//  m_      | out       | m_tvalid / m_tready  | tuser mode_used, tdata vel_x vel_y vel_z
//  cfg_    | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data (always ready)
//
// detection, altitude and mode words are taken while idle; a tick outside tracking goes
// to ST_OUT, and a tick in idle mode gives no output; a tracking tick holds the input while
// the one shared adder works through the three squares, the square root, a zero check,
// scale and divide for each axis, then output
// s_tready is low while a tick is in work and while its result waits in ST_OUT
// synchronous active-low reset restores the configuration, target and control registers and the mode state
`default_nettype none
module landing_guidance_mode_controller_unit (
    input  wire         aclk,
    input  wire         aresetn,
    // slave side
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [103:0] s_tdata,   // pos_a[31:0], pos_b[63:32], pos_c[95:64], new_mode[98:96]
    input  wire [1:0]   s_tuser,   // opcode[1:0]
    // master side
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [95:0] m_tdata,   // vel_x[31:0], vel_y[63:32], vel_z[95:64]
    output logic [1:0]  m_tuser,   // mode_used[1:0]
    // configuration writes
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire [2:0]   cfg_index,
    input  wire [31:0]  cfg_data
);

    localparam logic [5:0] SQ_LAST   = 6'd32;
    localparam logic [5:0] ROOT_LAST = 6'd32;
    localparam logic [5:0] PM_LAST   = 6'd30;
    localparam logic [5:0] DIV_LAST  = 6'd30;

    // configuration registers
    logic [30:0] max_speed_reg, climb_speed_reg, takeoff_alt_reg;
    logic [30:0] landing_alt_reg, capture_rad_reg, hover_ofs_reg;
    logic [15:0] tag_timeout_reg;

    // block state
    lgmc_pkg::mode_t  flight_mode_reg;
    logic [31:0]      tx_reg, ty_reg, tz_reg, alt_reg;
    logic [15:0]      ticks_reg;

    // sequencer and work registers
    lgmc_pkg::state_t state_reg, state_next;
    logic [32:0]      mag_reg [3];
    logic [2:0]       neg_reg;
    logic [66:0]      acc_reg;
    logic [65:0]      sh_reg;
    logic [32:0]      mq_reg;
    logic [5:0]       cnt_reg;
    logic [1:0]       comp_reg;
    logic [35:0]      rem_reg;
    logic [32:0]      root_reg;
    logic [30:0]      q_reg;
    logic [31:0]      vel_reg [3];
    logic [1:0]       used_reg;

    // output register
    logic             m_tvalid_reg;
    logic [95:0]      m_tdata_reg;
    logic [1:0]       m_tuser_reg;

    // input fields
    logic [31:0] pos_a, pos_b, pos_c;
    logic [2:0]  new_mode;
    logic        s_accept, out_load;

    assign pos_a    = s_tdata[31:0];
    assign pos_b    = s_tdata[63:32];
    assign pos_c    = s_tdata[95:64];
    assign new_mode = s_tdata[98:96];
    assign s_accept = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;
    assign out_load = (state_reg == lgmc_pkg::ST_OUT) & (~m_tvalid_reg | m_tready);

    // mode transitions applied at a tick
    logic [31:0]      abs_x, abs_y;
    logic [32:0]      gz, abs_gz;
    logic [15:0]      ticks_inc;
    lgmc_pkg::mode_t  m1, m2, m3;

    always_comb begin
        abs_x     = tx_reg[31] ? 32'd0 - tx_reg : tx_reg;
        abs_y     = ty_reg[31] ? 32'd0 - ty_reg : ty_reg;
        gz        = {tz_reg[31], tz_reg} + {2'b00, hover_ofs_reg};
        abs_gz    = gz[32] ? 33'd0 - gz : gz;
        ticks_inc = (ticks_reg == 16'hFFFF) ? ticks_reg : ticks_reg + 16'd1;
        m1 = flight_mode_reg;
        if (flight_mode_reg == lgmc_pkg::MODE_TAKEOFF &&
            $signed(alt_reg) > $signed({1'b0, takeoff_alt_reg})) begin
            m1 = lgmc_pkg::MODE_STAB;
        end
        m2 = m1;
        if (m1 == lgmc_pkg::MODE_TRACK && abs_x < {1'b0, capture_rad_reg} &&
            abs_y < {1'b0, capture_rad_reg} &&
            $signed(alt_reg) < $signed({1'b0, landing_alt_reg})) begin
            m2 = lgmc_pkg::MODE_LAND;
        end
        m3 = m2;
        if (m2 == lgmc_pkg::MODE_TRACK && ticks_inc > tag_timeout_reg) begin
            m3 = lgmc_pkg::MODE_LAND;
        end
    end

    // shared adder operand selection
    lgmc_pkg::alu_req_t alu_req;
    lgmc_pkg::alu_rsp_t alu_rsp;
    logic [35:0] root_trial;
    logic [33:0] div_trial;

    always_comb begin
        root_trial = {rem_reg[33:0], acc_reg[65:64]};
        div_trial  = {rem_reg[32:0], acc_reg[30]};
        alu_req.a   = acc_reg;
        alu_req.b   = {1'b0, sh_reg};
        alu_req.sub = 1'b0;
        case (state_reg)
            lgmc_pkg::ST_SQRT: begin
                alu_req.a   = {31'd0, root_trial};
                alu_req.b   = {32'd0, root_reg, 2'b01};
                alu_req.sub = 1'b1;
            end
            lgmc_pkg::ST_DIV: begin
                alu_req.a   = {33'd0, div_trial};
                alu_req.b   = {34'd0, root_reg};
                alu_req.sub = 1'b1;
            end
            default: begin
                alu_req.a   = acc_reg;
                alu_req.b   = {1'b0, sh_reg};
                alu_req.sub = 1'b0;
            end
        endcase
    end

    lgmc_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lgmc_pkg::ST_IDLE: begin
                if (s_accept && lgmc_pkg::opcode_t'(s_tuser) == lgmc_pkg::OP_TICK) begin
                    if (flight_mode_reg == lgmc_pkg::MODE_TRACK) begin
                        state_next = lgmc_pkg::ST_SQM;
                    end else if (flight_mode_reg != lgmc_pkg::MODE_IDLE) begin
                        state_next = lgmc_pkg::ST_OUT;
                    end
                end
            end
            lgmc_pkg::ST_SQM: begin
                if (cnt_reg == SQ_LAST && comp_reg == 2'd2) state_next = lgmc_pkg::ST_SQRT;
            end
            lgmc_pkg::ST_SQRT: begin
                if (cnt_reg == ROOT_LAST) state_next = lgmc_pkg::ST_CHK;
            end
            lgmc_pkg::ST_CHK: begin
                state_next = (root_reg == 33'd0) ? lgmc_pkg::ST_OUT : lgmc_pkg::ST_PMUL;
            end
            lgmc_pkg::ST_PMUL: begin
                if (cnt_reg == PM_LAST) state_next = lgmc_pkg::ST_DIV;
            end
            lgmc_pkg::ST_DIV: begin
                if (cnt_reg == DIV_LAST) begin
                    state_next = (comp_reg == 2'd2) ? lgmc_pkg::ST_OUT : lgmc_pkg::ST_PMUL;
                end
            end
            lgmc_pkg::ST_OUT: begin
                if (out_load) state_next = lgmc_pkg::ST_IDLE;
            end
            default: state_next = lgmc_pkg::ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_tready = (state_reg == lgmc_pkg::ST_IDLE);
        m_tvalid = m_tvalid_reg;
        m_tdata  = m_tdata_reg;
        m_tuser  = m_tuser_reg;
    end

    // control state, configuration and block state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= lgmc_pkg::ST_IDLE;
            max_speed_reg   <= 31'd65536;
            climb_speed_reg <= 31'd65536;
            takeoff_alt_reg <= 31'd655360;
            landing_alt_reg <= 31'd196608;
            capture_rad_reg <= 31'd6554;
            hover_ofs_reg   <= 31'd131072;
            tag_timeout_reg <= 16'd5;
            flight_mode_reg <= lgmc_pkg::MODE_TAKEOFF;
            tx_reg          <= 32'd0;
            ty_reg          <= 32'd0;
            tz_reg          <= 32'd0;
            alt_reg         <= 32'd0;
            ticks_reg       <= 16'hFFFF;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                case (lgmc_pkg::cfg_index_t'(cfg_index))
                    lgmc_pkg::CFG_MAX_SPEED:   max_speed_reg   <= cfg_data[30:0];
                    lgmc_pkg::CFG_CLIMB_SPEED: climb_speed_reg <= cfg_data[30:0];
                    lgmc_pkg::CFG_TAKEOFF_ALT: takeoff_alt_reg <= cfg_data[30:0];
                    lgmc_pkg::CFG_LANDING_ALT: landing_alt_reg <= cfg_data[30:0];
                    lgmc_pkg::CFG_CAPTURE_RAD: capture_rad_reg <= cfg_data[30:0];
                    lgmc_pkg::CFG_HOVER_OFS:   hover_ofs_reg   <= cfg_data[30:0];
                    lgmc_pkg::CFG_TAG_TIMEOUT: tag_timeout_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_accept) begin
                case (lgmc_pkg::opcode_t'(s_tuser))
                    lgmc_pkg::OP_DET: begin
                        tx_reg    <= lgmc_pkg::neg_sat(pos_b);
                        ty_reg    <= lgmc_pkg::neg_sat(pos_a);
                        tz_reg    <= lgmc_pkg::neg_sat(pos_c);
                        ticks_reg <= 16'd0;
                    end
                    lgmc_pkg::OP_ALT: alt_reg <= pos_c;
                    lgmc_pkg::OP_MODE: begin
                        if (new_mode <= 3'(lgmc_pkg::MODE_IDLE)) begin
                            flight_mode_reg <= lgmc_pkg::mode_t'(new_mode);
                        end
                    end
                    default: begin
                        flight_mode_reg <= m3;
                        ticks_reg       <= ticks_inc;
                    end
                endcase
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath of the sequencer
    logic [66:0] acc_add;
    logic [30:0] q_new;
    logic [32:0] mag_next;

    always_comb begin
        acc_add  = mq_reg[0] ? alu_rsp.res : acc_reg;
        q_new    = {q_reg[29:0], ~alu_rsp.borrow};
        case (comp_reg)
            2'd0:    mag_next = mag_reg[1];
            2'd1:    mag_next = mag_reg[2];
            default: mag_next = mag_reg[0];
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            lgmc_pkg::ST_IDLE: begin
                if (s_accept && lgmc_pkg::opcode_t'(s_tuser) == lgmc_pkg::OP_TICK) begin
                    used_reg   <= flight_mode_reg[1:0];
                    mag_reg[0] <= {1'b0, abs_x};
                    mag_reg[1] <= {1'b0, abs_y};
                    mag_reg[2] <= abs_gz;
                    neg_reg    <= {gz[32], ty_reg[31], tx_reg[31]};
                    acc_reg    <= 67'd0;
                    sh_reg     <= {33'd0, 1'b0, abs_x};
                    mq_reg     <= {1'b0, abs_x};
                    cnt_reg    <= 6'd0;
                    comp_reg   <= 2'd0;
                    vel_reg[0] <= 32'd0;
                    vel_reg[1] <= 32'd0;
                    case (flight_mode_reg)
                        lgmc_pkg::MODE_TAKEOFF: vel_reg[2] <= {1'b0, climb_speed_reg};
                        lgmc_pkg::MODE_LAND:    vel_reg[2] <= 32'd0 - {1'b0, max_speed_reg};
                        default:                vel_reg[2] <= 32'd0;
                    endcase
                end
            end
            // sum of squares by shift and add
            lgmc_pkg::ST_SQM: begin
                acc_reg <= acc_add;
                sh_reg  <= sh_reg << 1;
                mq_reg  <= mq_reg >> 1;
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == SQ_LAST) begin
                    cnt_reg  <= 6'd0;
                    comp_reg <= comp_reg + 2'd1;
                    sh_reg   <= {33'd0, mag_next};
                    mq_reg   <= mag_next;
                    rem_reg  <= 36'd0;
                    root_reg <= 33'd0;
                    if (comp_reg == 2'd2) comp_reg <= 2'd0;
                end
            end
            // square root, two bits a step
            lgmc_pkg::ST_SQRT: begin
                acc_reg <= acc_reg << 2;
                cnt_reg <= cnt_reg + 6'd1;
                if (!alu_rsp.borrow) begin
                    rem_reg  <= alu_rsp.res[35:0];
                    root_reg <= {root_reg[31:0], 1'b1};
                end else begin
                    rem_reg  <= root_trial;
                    root_reg <= {root_reg[31:0], 1'b0};
                end
                if (cnt_reg == ROOT_LAST) cnt_reg <= 6'd0;
            end
            lgmc_pkg::ST_CHK: begin
                acc_reg  <= 67'd0;
                sh_reg   <= {33'd0, mag_reg[0]};
                mq_reg   <= {2'b00, max_speed_reg};
                cnt_reg  <= 6'd0;
                comp_reg <= 2'd0;
            end
            // max_speed times component magnitude
            lgmc_pkg::ST_PMUL: begin
                acc_reg <= acc_add;
                sh_reg  <= sh_reg << 1;
                mq_reg  <= mq_reg >> 1;
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == PM_LAST) begin
                    cnt_reg <= 6'd0;
                    rem_reg <= {3'd0, acc_add[63:31]};
                    q_reg   <= 31'd0;
                end
            end
            // restoring divide by the norm, one quotient bit a step
            lgmc_pkg::ST_DIV: begin
                acc_reg <= acc_reg << 1;
                cnt_reg <= cnt_reg + 6'd1;
                q_reg   <= q_new;
                if (!alu_rsp.borrow) begin
                    rem_reg <= {2'b00, alu_rsp.res[33:0]};
                end else begin
                    rem_reg <= {2'b00, div_trial};
                end
                if (cnt_reg == DIV_LAST) begin
                    vel_reg[comp_reg] <= neg_reg[comp_reg] ? 32'd0 - {1'b0, q_new}
                                                           : {1'b0, q_new};
                    cnt_reg  <= 6'd0;
                    comp_reg <= comp_reg + 2'd1;
                    acc_reg  <= 67'd0;
                    sh_reg   <= {33'd0, mag_next};
                    mq_reg   <= {2'b00, max_speed_reg};
                end
            end
            lgmc_pkg::ST_OUT: begin
                if (out_load) begin
                    m_tdata_reg <= {vel_reg[2], vel_reg[1], vel_reg[0]};
                    m_tuser_reg <= used_reg;
                end
            end
            default: ;
        endcase
    end

    // root remainder never exceeds twice the partial root
    a_root_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == lgmc_pkg::ST_SQRT |-> rem_reg <= {2'b00, root_reg, 1'b0})
        else $error("root remainder out of range");

    // divide remainder stays below the norm
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == lgmc_pkg::ST_DIV |-> rem_reg < {3'd0, root_reg})
        else $error("divide remainder not below norm");

    // a tracking tick starts the sum of squares
    a_track_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tuser == 2'(lgmc_pkg::OP_TICK) &&
        flight_mode_reg == lgmc_pkg::MODE_TRACK |=> state_reg == lgmc_pkg::ST_SQM)
        else $error("tracking tick did not start sequencer");

    // an idle tick leaves the sequencer idle
    a_idle_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tuser == 2'(lgmc_pkg::OP_TICK) &&
        flight_mode_reg == lgmc_pkg::MODE_IDLE |=> state_reg == lgmc_pkg::ST_IDLE)
        else $error("idle tick produced work");

endmodule
`default_nettype wire

// ===== tb/landing_guidance_mode_controller_unit_tb.sv =====
// landing_guidance_mode_controller_unit_tb: self-checking bench for the guidance mode controller
// depends on lgmc_pkg and landing_guidance_mode_controller_unit; drives event words, checks
// velocity words against an internal predictor of modes, targets and tracking vectors
`default_nettype none
module landing_guidance_mode_controller_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 20000;
    localparam int DRAIN    = 400;

    // mode codes as they appear in mode_used, and codes outside the valid range
    localparam logic [1:0] USED_TAKEOFF = 2'(lgmc_pkg::MODE_TAKEOFF);
    localparam logic [1:0] USED_STAB    = 2'(lgmc_pkg::MODE_STAB);
    localparam logic [1:0] USED_TRACK   = 2'(lgmc_pkg::MODE_TRACK);
    localparam logic [1:0] USED_LAND    = 2'(lgmc_pkg::MODE_LAND);
    localparam logic [2:0] BAD_MODE     = 3'd7;
    localparam logic [2:0] BAD_INDEX    = 3'd7;

    typedef struct packed {
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
        logic [1:0]  mode;
    } vel_word_t;

    typedef struct {
        lgmc_pkg::opcode_t op;
        logic [31:0] pa;
        logic [31:0] pb;
        logic [31:0] pc;
        logic [2:0]  nm;
        bit          known;
        vel_word_t   want;
    } event_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    landing_guidance_mode_controller_unit dut (.*);

    always #5 aclk = ~aclk;

    // predictor state
    logic [30:0] r_max_speed, r_climb, r_takeoff_alt, r_land_alt, r_capture, r_hover;
    logic [15:0] r_timeout;
    logic [2:0]  p_mode;
    logic signed [31:0] p_tx, p_ty, p_tz, p_alt;
    logic [15:0] p_ticks;

    vel_word_t   pending_vel[$];
    int          errors = 0;
    int          n_items = 0;
    int          n_results = 0;
    int          n_tracking = 0;
    int          idle_cycles = 0;
    bit          quiet = 1'b0;
    bit          hold_off = 1'b0;
    bit          long_hold = 1'b0;

    function automatic logic [63:0] abs_val(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic [32:0] sqrt_floor(input logic [65:0] t);
        logic [32:0] r;
        logic [65:0] sq;
        r = '0;
        for (int i = 32; i >= 0; i--) begin
            sq = ({33'd0, r | (33'd1 << i)}) * ({33'd0, r | (33'd1 << i)});
            if (sq <= t) r = r | (33'd1 << i);
        end
        return r;
    endfunction

    function automatic logic [31:0] scale_axis(input logic signed [63:0] g,
                                               input logic [32:0] norm);
        logic [95:0] m;
        m = ({65'd0, r_max_speed} * {32'd0, abs_val(g)}) / norm;
        return g < 0 ? -m[31:0] : m[31:0];
    endfunction

    function automatic logic [31:0] neg_ref(input logic [31:0] v);
        return v == 32'h8000_0000 ? 32'h7FFF_FFFF : 32'd0 - v;
    endfunction

    // apply one accepted event to the predicted state
    function automatic void predict_event(input lgmc_pkg::opcode_t op, input logic [31:0] pa,
                                          input logic [31:0] pb, input logic [31:0] pc,
                                          input logic [2:0] nm);
        vel_word_t w;
        logic signed [63:0] gx, gy, gz;
        logic [65:0] sum;
        logic [32:0] norm;
        case (op)
            lgmc_pkg::OP_DET: begin
                p_tx = neg_ref(pb);
                p_ty = neg_ref(pa);
                p_tz = neg_ref(pc);
                p_ticks = 16'd0;
            end
            lgmc_pkg::OP_ALT: p_alt = pc;
            lgmc_pkg::OP_MODE: if (nm <= lgmc_pkg::MODE_IDLE) p_mode = nm;
            default: begin
                if (p_mode <= lgmc_pkg::MODE_LAND) begin
                    w = '0;
                    w.mode = p_mode[1:0];
                    if (p_mode == lgmc_pkg::MODE_TAKEOFF) begin
                        w.vz = {1'b0, r_climb};
                    end else if (p_mode == lgmc_pkg::MODE_TRACK) begin
                        gx = p_tx;
                        gy = p_ty;
                        gz = 64'(p_tz) + 64'({1'b0, r_hover});
                        sum = 66'(abs_val(gx) * abs_val(gx)) + 66'(abs_val(gy) * abs_val(gy))
                            + 66'(abs_val(gz) * abs_val(gz));
                        norm = sqrt_floor(sum);
                        if (norm != 0) begin
                            w.vx = scale_axis(gx, norm);
                            w.vy = scale_axis(gy, norm);
                            w.vz = scale_axis(gz, norm);
                        end
                        n_tracking++;
                    end else if (p_mode == lgmc_pkg::MODE_LAND) begin
                        w.vz = -{1'b0, r_max_speed};
                    end
                    pending_vel.push_back(w);
                end
                if (p_mode == lgmc_pkg::MODE_TAKEOFF && p_alt > $signed({1'b0, r_takeoff_alt}))
                    p_mode = lgmc_pkg::MODE_STAB;
                if (p_mode == lgmc_pkg::MODE_TRACK && abs_val(64'(p_tx)) < r_capture
                    && abs_val(64'(p_ty)) < r_capture && p_alt < $signed({1'b0, r_land_alt}))
                    p_mode = lgmc_pkg::MODE_LAND;
                if (p_ticks != 16'hFFFF) p_ticks++;
                if (p_mode == lgmc_pkg::MODE_TRACK && p_ticks > r_timeout)
                    p_mode = lgmc_pkg::MODE_LAND;
            end
        endcase
    endfunction

    // register write through the config channel and into the predictor
    task automatic write_reg(input lgmc_pkg::cfg_index_t idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            lgmc_pkg::CFG_MAX_SPEED:   r_max_speed = val[30:0];
            lgmc_pkg::CFG_CLIMB_SPEED: r_climb = val[30:0];
            lgmc_pkg::CFG_TAKEOFF_ALT: r_takeoff_alt = val[30:0];
            lgmc_pkg::CFG_LANDING_ALT: r_land_alt = val[30:0];
            lgmc_pkg::CFG_CAPTURE_RAD: r_capture = val[30:0];
            lgmc_pkg::CFG_HOVER_OFS:   r_hover = val[30:0];
            lgmc_pkg::CFG_TAG_TIMEOUT: r_timeout = val[15:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // offer one event word at a falling edge and wait for acceptance
    task automatic send_event(input lgmc_pkg::opcode_t op, input logic [31:0] pa,
                              input logic [31:0] pb, input logic [31:0] pc,
                              input logic [2:0] nm);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = {5'd0, nm, pc, pb, pa};
        do @(posedge aclk); while (!s_tready);
        predict_event(op, pa, pb, pc, nm);
        n_items++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // wait until every expected word has come out, then let the block settle
    task automatic drain();
        while (pending_vel.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] rnd_pos();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            default: return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
        endcase
    endfunction

    // random event, weighted toward flight sequences that reach tracking and landing
    task automatic random_event();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: send_event(lgmc_pkg::OP_TICK, $urandom(), $urandom(), $urandom(),
                                   3'($urandom()));
            4, 5: send_event(lgmc_pkg::OP_DET, rnd_pos(), rnd_pos(), rnd_pos(),
                             3'($urandom()));
            6: send_event(lgmc_pkg::OP_ALT, $urandom(), $urandom(),
                          $urandom_range(0, 1) ? rnd_pos() : $urandom_range(0, 32'h000C_0000),
                          3'($urandom()));
            default: send_event(lgmc_pkg::OP_MODE, $urandom(), $urandom(), $urandom(),
                                $urandom_range(0, 3) == 0 ? 3'($urandom())
                                                          : lgmc_pkg::MODE_TRACK);
        endcase
    endtask

    // result checker
    always @(posedge aclk) begin
        vel_word_t got, w;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser};
            n_results++;
            if (pending_vel.size() == 0) begin
                $error("unexpected velocity word vx=%h vy=%h vz=%h mode=%0d",
                       got.vx, got.vy, got.vz, got.mode);
                errors++;
            end else begin
                w = pending_vel.pop_front();
                if (got.vx !== w.vx) begin
                    $error("vel_x expected %h got %h", w.vx, got.vx); errors++;
                end
                if (got.vy !== w.vy) begin
                    $error("vel_y expected %h got %h", w.vy, got.vy); errors++;
                end
                if (got.vz !== w.vz) begin
                    $error("vel_z expected %h got %h", w.vz, got.vz); errors++;
                end
                if (got.mode !== w.mode) begin
                    $error("mode_used expected %0d got %0d", w.mode, got.mode); errors++;
                end
            end
        end
    end

    // receiver stalls: random bursts, one long hold-off, none at the end
    always @(negedge aclk) begin
        if (hold_off || long_hold || (!quiet && $urandom_range(0, 7) == 0)) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        int stall;
        forever begin
            @(negedge aclk);
            if (!quiet && !hold_off && $urandom_range(0, 15) == 0) begin
                stall = $urandom_range(1, 18);
                hold_off = 1'b1;
                repeat (stall) @(negedge aclk);
                hold_off = 1'b0;
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    event_row_t dir_rows[$];

    function automatic event_row_t row(input lgmc_pkg::opcode_t op, input logic [31:0] pa,
                                       input logic [31:0] pb, input logic [31:0] pc,
                                       input logic [2:0] nm, input bit known,
                                       input vel_word_t want);
        event_row_t r;
        r.op = op; r.pa = pa; r.pb = pb; r.pc = pc; r.nm = nm;
        r.known = known; r.want = want;
        return r;
    endfunction

    initial begin
        vel_word_t z;
        z = '0;
        r_max_speed = 31'd65536; r_climb = 31'd65536; r_takeoff_alt = 31'd655360;
        r_land_alt = 31'd196608; r_capture = 31'd6554; r_hover = 31'd131072;
        r_timeout = 16'd5;
        p_mode = lgmc_pkg::MODE_TAKEOFF;
        p_tx = 0; p_ty = 0; p_tz = 0; p_alt = 0; p_ticks = 16'hFFFF;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table: reset behavior, extremes, ignored commands, zero vector
        dir_rows.push_back(row(lgmc_pkg::OP_TICK, '0, '0, '0, '0, 1,
                               '{0, 0, 32'd65536, USED_TAKEOFF}));
        dir_rows.push_back(row(lgmc_pkg::OP_ALT, '0, '0, 32'h7FFF_FFFF, '0, 0, z));
        dir_rows.push_back(row(lgmc_pkg::OP_TICK, '0, '0, '0, '0, 1,
                               '{0, 0, 32'd65536, USED_TAKEOFF}));
        dir_rows.push_back(row(lgmc_pkg::OP_TICK, '0, '0, '0, '0, 1, '{0, 0, 0, USED_STAB}));
        dir_rows.push_back(row(lgmc_pkg::OP_MODE, '0, '0, '0, BAD_MODE, 0, z));
        dir_rows.push_back(row(lgmc_pkg::OP_TICK, '0, '0, '0, '0, 1, '{0, 0, 0, USED_STAB}));
        dir_rows.push_back(row(lgmc_pkg::OP_MODE, '1, '1, '1, lgmc_pkg::MODE_LAND, 0, z));
        dir_rows.push_back(row(lgmc_pkg::OP_TICK, '0, '0, '0, '0, 1,
                               '{0, 0, -32'sd65536, USED_LAND}));
        dir_rows.push_back(row(lgmc_pkg::OP_MODE, '0, '0, '0, lgmc_pkg::MODE_IDLE, 0, z));
        dir_rows.push_back(row(lgmc_pkg::OP_TICK, '0, '0, '0, '0, 0, z));
        dir_rows.push_back(row(lgmc_pkg::OP_DET, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               '0, 0, z));
        dir_rows.push_back(row(lgmc_pkg::OP_MODE, '0, '0, '0, lgmc_pkg::MODE_TRACK, 0, z));
        dir_rows.push_back(row(lgmc_pkg::OP_TICK, '0, '0, '0, '0, 0, z));
        dir_rows.push_back(row(lgmc_pkg::OP_DET, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               '0, 0, z));
        dir_rows.push_back(row(lgmc_pkg::OP_MODE, '0, '0, '0, lgmc_pkg::MODE_TRACK, 0, z));
        dir_rows.push_back(row(lgmc_pkg::OP_TICK, '0, '0, '0, '0, 0, z));
        // target exactly hover_offset below: zero tracking vector
        dir_rows.push_back(row(lgmc_pkg::OP_DET, '0, '0, 32'd131072, '0, 0, z));
        dir_rows.push_back(row(lgmc_pkg::OP_MODE, '0, '0, '0, lgmc_pkg::MODE_TRACK, 0, z));
        dir_rows.push_back(row(lgmc_pkg::OP_ALT, '0, '0, 32'h8000_0000, '0, 0, z));
        dir_rows.push_back(row(lgmc_pkg::OP_TICK, '0, '0, '0, '0, 1, '{0, 0, 0, USED_TRACK}));
        dir_rows.push_back(row(lgmc_pkg::OP_TICK, '0, '0, '0, '0, 1,
                               '{0, 0, -32'sd65536, USED_LAND}));
        dir_rows.push_back(row(lgmc_pkg::OP_DET, 32'h0001_0000, 32'hFFFF_0000, 32'hFFFE_0000,
                               '0, 0, z));
        dir_rows.push_back(row(lgmc_pkg::OP_MODE, '0, '0, '0, lgmc_pkg::MODE_TRACK, 0, z));
        dir_rows.push_back(row(lgmc_pkg::OP_TICK, '0, '0, '0, '0, 0, z));
        foreach (dir_rows[i]) begin
            int before_n;
            before_n = pending_vel.size();
            send_event(dir_rows[i].op, dir_rows[i].pa, dir_rows[i].pb, dir_rows[i].pc,
                       dir_rows[i].nm);
            if (dir_rows[i].known && pending_vel.size() > before_n
                && pending_vel[$] !== dir_rows[i].want) begin
                $error("directed row %0d: predictor disagrees with table", i);
                errors++;
            end
        end
        drain();

        // register settings, extremes included, with random traffic after each
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    write_reg(lgmc_pkg::CFG_MAX_SPEED, 32'hFFFF_FFFF);
                    write_reg(lgmc_pkg::CFG_CLIMB_SPEED, 32'h7FFF_FFFF);
                    write_reg(lgmc_pkg::CFG_TAKEOFF_ALT, 32'd0);
                    write_reg(lgmc_pkg::CFG_LANDING_ALT, 32'h7FFF_FFFF);
                    write_reg(lgmc_pkg::CFG_CAPTURE_RAD, 32'h7FFF_FFFF);
                    write_reg(lgmc_pkg::CFG_HOVER_OFS, 32'h7FFF_FFFF);
                    write_reg(lgmc_pkg::CFG_TAG_TIMEOUT, 32'hFFFF_FFFF);
                end
                1: begin
                    write_reg(lgmc_pkg::CFG_MAX_SPEED, 32'd0);
                    write_reg(lgmc_pkg::CFG_CLIMB_SPEED, 32'd0);
                    write_reg(lgmc_pkg::CFG_TAKEOFF_ALT, 32'h7FFF_FFFF);
                    write_reg(lgmc_pkg::CFG_LANDING_ALT, 32'd0);
                    write_reg(lgmc_pkg::CFG_CAPTURE_RAD, 32'd0);
                    write_reg(lgmc_pkg::CFG_HOVER_OFS, 32'd0);
                    write_reg(lgmc_pkg::CFG_TAG_TIMEOUT, 32'd0);
                end
                2: begin
                    write_reg(lgmc_pkg::cfg_index_t'(BAD_INDEX), $urandom());
                    for (int k = 0; k <= lgmc_pkg::CFG_TAG_TIMEOUT; k++)
                        write_reg(lgmc_pkg::cfg_index_t'(k), $urandom());
                end
                default: begin
                    write_reg(lgmc_pkg::CFG_MAX_SPEED, $urandom_range(1, 32'h0004_0000));
                    write_reg(lgmc_pkg::CFG_CLIMB_SPEED, $urandom_range(0, 32'h0004_0000));
                    write_reg(lgmc_pkg::CFG_TAKEOFF_ALT, $urandom_range(0, 32'h000A_0000));
                    write_reg(lgmc_pkg::CFG_LANDING_ALT, $urandom_range(0, 32'h0006_0000));
                    write_reg(lgmc_pkg::CFG_CAPTURE_RAD, $urandom_range(0, 32'h0002_0000));
                    write_reg(lgmc_pkg::CFG_HOVER_OFS, $urandom_range(0, 32'h0004_0000));
                    write_reg(lgmc_pkg::CFG_TAG_TIMEOUT, $urandom_range(0, 12));
                end
            endcase
            if (phase == 3) begin
                // long receiver hold-off while events keep coming
                fork
                    begin
                        @(negedge aclk);
                        long_hold = 1'b1;
                        repeat (2000) @(negedge aclk);
                        long_hold = 1'b0;
                    end
                    begin
                        send_event(lgmc_pkg::OP_MODE, '0, '0, '0, lgmc_pkg::MODE_LAND);
                        repeat (6) send_event(lgmc_pkg::OP_TICK, '0, '0, '0, '0);
                    end
                join
            end
            if (phase == 4) quiet = 1'b1;
            repeat (80) random_event();
            drain();
        end

        $display("run covered %0d events, %0d velocity words, %0d tracking ticks",
                 n_items, n_results, n_tracking);
        $display("register settings from zero to full scale, idling and a long stall");
        if (errors == 0 && pending_vel.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
`default_nettype wire
